### rtl/u2l_pkg.sv
// ----------------------------------------------------------------------------
// u2l_pkg
// Shared types and constants for the UTF-8 to Latin-1 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2l_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int JOB_DEPTH_DEF  = 4;
   localparam int RSP_DEPTH_DEF  = 4;

   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] PAYLOAD2_MASK = 8'h1F;
   localparam logic [7:0] PAYLOADC_MASK = 8'h3F;
   localparam logic [7:0] LATIN1_MAX = 8'hFF;
   localparam logic [7:0] SUBST_CHAR = 8'h3F;   // '?'

   localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN_2    = 3'd2;
   localparam logic [2:0] SEQ_LEN_3    = 3'd3;
   localparam logic [2:0] SEQ_LEN_4    = 3'd4;

   // work for the back end: up to four text bytes, then optionally the end marker
   typedef struct packed {
      logic [3:0][7:0] text_bytes;
      logic [2:0]      text_count;
      logic            is_term;
   } job_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_is_end;
      logic [15:0] written_count;
      logic        run_last;
   } result_type;

   localparam int JOB_WIDTH    = $bits(job_type);
   localparam int RESULT_WIDTH = $bits(result_type);

endpackage

`default_nettype wire

### rtl/utf8_to_latin1_converter_top.sv
// Results reach the rsp_ ports through the registered job queue and result queue.
// Throughput: one request per cycle while the job queue has room; the output stage
// emits one result per cycle while the result queue has room, and holds each request
// for its results and any budget cut; the job queue between the stages absorbs them.
// Reset: synchronous; clears both queues, open sequence, count, and sets capacity 65535.
// ----------------------------------------------------------------------------
// utf8_to_latin1_converter_top
// UTF-8 to Latin-1 converter: sequence tracker, job queue, output stage and
// result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_latin1_converter_top
   import u2l_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int JOB_DEPTH  = JOB_DEPTH_DEF,
   parameter int RSP_DEPTH  = RSP_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_is_terminator,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_is_end,
   output logic [15:0]      rsp_written_count,
   output logic             rsp_run_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   job_type    front_job, head_job;
   logic       front_valid, job_full, job_empty, job_pop;
   logic       accept;
   result_type back_result, head_result;
   logic       result_push, result_full;

   assign accept    = req_push && !req_full;
   assign req_full  = job_full;
   assign csr_ready = 1'b1;

   u2l_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .is_terminator (req_is_terminator),
      .job           (front_job),
      .job_valid     (front_valid)
   );

   u2l_fifo #(
      .WIDTH (JOB_WIDTH),
      .DEPTH (JOB_DEPTH)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_job),
      .full      (job_full),
      .pop       (job_pop),
      .head_data (head_job),
      .empty     (job_empty)
   );

   u2l_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .job         (head_job),
      .job_valid   (!job_empty),
      .job_pop     (job_pop),
      .result      (back_result),
      .result_push (result_push),
      .result_full (result_full)
   );

   u2l_fifo #(
      .WIDTH (RESULT_WIDTH),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (result_full),
      .pop       (rsp_pop),
      .head_data (head_result),
      .empty     (rsp_empty)
   );

   assign rsp_out_byte      = head_result.out_byte;
   assign rsp_out_is_end    = head_result.out_is_end;
   assign rsp_written_count = head_result.written_count;
   assign rsp_run_last      = head_result.run_last;

endmodule

`default_nettype wire

### rtl/u2l_fifo.sv
// ----------------------------------------------------------------------------
// u2l_fifo
// Small register queue with a combinational head read.
// ----------------------------------------------------------------------------
`default_nettype none

module u2l_fifo
   import u2l_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/u2l_front.sv
// ----------------------------------------------------------------------------
// u2l_front
// UTF-8 sequence tracker: buffers open sequences and turns each request
// into a job of candidate text bytes for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module u2l_front
   import u2l_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       is_terminator,
   output job_type         job,
   output logic            job_valid
);

   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      pcnt_ff, pcnt_in;
   logic [2:0]      elen_ff, elen_in;

   logic       is_cont;
   logic [2:0] want;
   logic [1:0] pcnt_next;
   logic [7:0] decoded;

   always_comb begin
      is_cont = ((data_byte & CONT_MASK) == CONT_CODE);
      if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
         want = SEQ_LEN_2;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
         want = SEQ_LEN_3;
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
         want = SEQ_LEN_4;
      end else begin
         want = SEQ_LEN_NONE;
      end
      pcnt_next = pcnt_ff + 2'd1;
      // two-byte code point fits in Latin-1 only when lead bits [4:2] are zero
      if ((elen_ff == SEQ_LEN_2) && ((pend_ff[0] & PAYLOAD2_MASK) <= 8'h03)) begin
         decoded = {pend_ff[0][1:0], data_byte[5:0] & PAYLOADC_MASK[5:0]};
      end else begin
         decoded = SUBST_CHAR;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      pcnt_in = pcnt_ff;
      elen_in = elen_ff;
      job.text_bytes = {8'h00, pend_ff[2], pend_ff[1], pend_ff[0]};
      job.text_count = 3'd0;
      job.is_term    = 1'b0;

      if (is_terminator) begin
         job.text_count = {1'b0, pcnt_ff};
         job.is_term    = 1'b1;
         pcnt_in = 2'd0;
         elen_in = SEQ_LEN_NONE;
      end else if ((pcnt_ff != 2'd0) && is_cont && (pcnt_ff != 2'd3)) begin
         pend_in[pcnt_ff] = data_byte;
         if ({1'b0, pcnt_next} >= elen_ff) begin
            job.text_bytes[0] = decoded;
            job.text_count    = 3'd1;
            pcnt_in = 2'd0;
            elen_in = SEQ_LEN_NONE;
         end else begin
            pcnt_in = pcnt_next;
         end
      end else if ((pcnt_ff != 2'd0) && is_cont) begin
         // fourth byte closes a four-byte sequence
         job.text_bytes[0] = SUBST_CHAR;
         job.text_count    = 3'd1;
         pcnt_in = 2'd0;
         elen_in = SEQ_LEN_NONE;
      end else begin
         // flush what is buffered raw, then start a new character
         job.text_count = {1'b0, pcnt_ff};
         if (data_byte[7] && (want != SEQ_LEN_NONE)) begin
            pend_in[0] = data_byte;
            pcnt_in    = 2'd1;
            elen_in    = want;
         end else begin
            job.text_bytes[pcnt_ff] = data_byte;
            job.text_count = {1'b0, pcnt_ff} + 3'd1;
            pcnt_in = 2'd0;
            elen_in = SEQ_LEN_NONE;
         end
      end

      job_valid = accept && (job.is_term || (job.text_count != 3'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= 2'd0;
         elen_ff <= SEQ_LEN_NONE;
      end else if (accept) begin
         pcnt_ff <= pcnt_in;
         elen_ff <= elen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

`default_nettype wire

### rtl/u2l_back.sv
// ----------------------------------------------------------------------------
// u2l_back
// Output stage: walks each job one entry per cycle while the result queue is
// not full, applies the text budget and counts written bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module u2l_back
   import u2l_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [15:0] csr_data,
   input  wire job_type     job,
   input  wire logic        job_valid,
   output logic             job_pop,
   output result_type       result,
   output logic             result_push,
   input  wire logic        result_full
);

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [2:0]            idx_ff, idx_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  reached_ff, reached_in;
   logic [15:0]           cap_ff;

   logic [15:0]           budget;
   logic [CMP_W-1:0]      budget_ext, cnt_ext, inc_ext;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic                  is_text, last_entry, allowed, next_ok;

   always_comb begin
      budget     = (cap_ff != 16'd0) ? cap_ff - 16'd1 : 16'd0;
      budget_ext = CMP_W'(budget);
      cnt_inc    = cnt_ff + COUNT_BITS'(1);
      cnt_ext    = CMP_W'(cnt_ff);
      inc_ext    = CMP_W'(cnt_inc);
      is_text    = (idx_ff < job.text_count);
      last_entry = !job.is_term && (idx_ff == job.text_count - 3'd1);
      allowed    = !reached_ff && (cnt_ext < budget_ext) && (cnt_ff != COUNT_MAX);
      next_ok    = (inc_ext < budget_ext) && (cnt_inc != COUNT_MAX);

      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      reached_in  = reached_ff;
      job_pop     = 1'b0;
      result_push = 1'b0;
      result.out_byte      = job.text_bytes[idx_ff[1:0]];
      result.out_is_end    = 1'b0;
      result.written_count = inc_ext[15:0];
      // a terminator job always closes with its end marker
      result.run_last      = last_entry || (!job.is_term && !next_ok);

      if (job_valid) begin
         if (is_text && allowed) begin
            if (!result_full) begin
               result_push = 1'b1;
               cnt_in      = cnt_inc;
               if (last_entry) begin
                  job_pop = 1'b1;
                  idx_in  = 3'd0;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end else if (is_text) begin
            // refused: the rest of this job's text goes nowhere
            reached_in = 1'b1;
            if (job.is_term) begin
               idx_in = job.text_count;
            end else begin
               job_pop = 1'b1;
               idx_in  = 3'd0;
            end
         end else begin
            result.out_byte      = 8'h00;
            result.out_is_end    = 1'b1;
            result.written_count = cnt_ext[15:0];
            result.run_last      = 1'b1;
            if (!result_full) begin
               result_push = 1'b1;
               job_pop     = 1'b1;
               idx_in      = 3'd0;
               cnt_in      = '0;
               reached_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= 3'd0;
         cnt_ff     <= '0;
         reached_ff <= 1'b0;
         cap_ff     <= CAPACITY_RESET;
      end else begin
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         reached_ff <= reached_in;
         if (csr_write) begin
            cap_ff <= csr_data;
         end
      end
   end

endmodule

`default_nettype wire
